// ===== sv/nearest_arm_hit_test_unit_assert.svh =====
// Assertion macros for the nearest arm hit test unit.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef NEAREST_ARM_HIT_TEST_UNIT_ASSERT_SVH
`define NEAREST_ARM_HIT_TEST_UNIT_ASSERT_SVH

// hold: antecedent implies consequent in the same cycle
`define NAHIT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nearest arm hit test check failed");

// hold: antecedent implies consequent in the next cycle
`define NAHIT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nearest arm hit test check failed");

`endif

// ===== sv/nahit_pkg.sv =====
// Shared types, constants and functions of the nearest arm hit test unit.
// No dependencies.
package nahit_pkg;

    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int DOT_W     = PROD_W + 1;
    localparam int LEN_W     = PROD_W - 1;
    localparam int FRAC_W    = 16;
    localparam int TQ_W      = FRAC_W + 1;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STG   = FRAC_W / DIV_BITS;
    localparam int TP_W      = DIFF_W + TQ_W + 1;
    localparam int ERR_W     = TP_W + 1;
    localparam int MAG_W     = 34;
    localparam int HALF_W    = MAG_W / 2;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int DIST_W    = SQ_W + 1;
    localparam int TOL_W     = 15;
    localparam int TOLSQ_W   = 2 * TOL_W;
    localparam int ARMS      = 3;
    localparam int ARM_LAT   = 7 + DIV_STG;
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 8;
    localparam int HIT_W     = 2;

    localparam logic [HIT_W-1:0] HIT_NONE = 2'd0;
    localparam logic [HIT_W-1:0] HIT_X    = 2'd1;
    localparam logic [HIT_W-1:0] HIT_Y    = 2'd2;
    localparam logic [HIT_W-1:0] HIT_Z    = 2'd3;

    localparam logic [TOL_W-1:0] TOL_RESET = 15'd128;

    typedef struct packed {
        logic [LEN_W-1:0]  rem;
        logic [FRAC_W-1:0] quo;
    } t_div;

    function automatic t_div div_step(t_div cur, logic [LEN_W-1:0] den);
        t_div             nxt;
        logic [LEN_W:0]   sh;
        nxt = cur;
        for (int k = 0; k < DIV_BITS; k++) begin
            sh = {nxt.rem, 1'b0};
            nxt.quo = {nxt.quo[FRAC_W-2:0], 1'b0};
            if (sh >= {1'b0, den}) begin
                sh = sh - {1'b0, den};
                nxt.quo[0] = 1'b1;
            end
            nxt.rem = sh[LEN_W-1:0];
        end
        return nxt;
    endfunction

endpackage

// ===== sv/nearest_arm_hit_test_unit.sv =====
// Top level of the nearest arm hit test unit: stream ports, arm pipelines, selection.
// Depends on nahit_pkg, nahit_arm and nearest_arm_hit_test_unit_assert.svh.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  one hit test query
//  m_axis    out        m_axis_tvalid/m_axis_tready  hit arm code
//  cfg       in         i_cfg_valid/o_cfg_ready      grab tolerance
//
// One query per cycle unless a held result stalls the pipeline.
// The segment parameter comes from a divider that resolves 4 bits per stage.
// Reset clears all valid bits and loads the tolerance with 128.
// A held result stalls the whole pipeline; s_axis_tready follows that stall.
module nearest_arm_hit_test_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // cursor_x, cursor_y, origin_x, origin_y, tip_x_axis_x, tip_x_axis_y,
    // tip_y_axis_x, tip_y_axis_y, tip_z_axis_x, tip_z_axis_y, arm_visible, pad
    input  logic [nahit_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // hit_axis, pad
    output logic [nahit_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nahit_pkg::TOL_W-1:0]         i_cfg_data
);
    import nahit_pkg::*;

    logic                  n_en;
    logic [TOL_W-1:0]      r_tol;
    logic [TOLSQ_W-1:0]    r_tol_sq;
    logic [ARM_LAT-1:0]    r_vld;
    logic [ARMS-1:0]       r_vis [ARM_LAT];
    logic [DIST_W-1:0]     w_dist [ARMS];
    logic [DIST_W-1:0]     n_lim;
    logic                  r_cv;
    logic [ARMS-1:0]       r_cand;
    logic [ARMS-1:0]       r_cvis;
    logic                  r_lt10, r_lt20, r_lt21;
    logic                  r_out_valid;
    logic [HIT_W-1:0]      r_hit;
    logic [ARMS-1:0]       r_out_vis;
    logic [HIT_W-1:0]      n_hit;

    assign n_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = n_en;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - HIT_W){1'b0}}, r_hit};
    assign n_lim         = DIST_W'(r_tol_sq) << (2 * FRAC_W);

    for (genvar a = 0; a < ARMS; a++) begin : g_arm
        nahit_arm u_arm (
            .i_clk   (i_clk),
            .i_en    (n_en),
            .i_cx    (s_axis_tdata[15:0]),
            .i_cy    (s_axis_tdata[31:16]),
            .i_ox    (s_axis_tdata[47:32]),
            .i_oy    (s_axis_tdata[63:48]),
            .i_tx    (s_axis_tdata[64 + 32*a +: COORD_W]),
            .i_ty    (s_axis_tdata[80 + 32*a +: COORD_W]),
            .o_dist2 (w_dist[a])
        );
    end

    always_comb begin
        n_hit = HIT_NONE;
        if (r_cand[0]) begin
            n_hit = HIT_X;
        end
        if (r_cand[1] && (!r_cand[0] || r_lt10)) begin
            n_hit = HIT_Y;
        end
        unique case (n_hit)
            HIT_NONE: if (r_cand[2]) n_hit = HIT_Z;
            HIT_X:    if (r_cand[2] && r_lt20) n_hit = HIT_Z;
            HIT_Y:    if (r_cand[2] && r_lt21) n_hit = HIT_Z;
            default:  n_hit = HIT_Z;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol       <= TOL_RESET;
            r_tol_sq    <= TOLSQ_W'(TOL_RESET) * TOLSQ_W'(TOL_RESET);
            r_vld       <= '0;
            r_cv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_tol <= i_cfg_data;
            end
            r_tol_sq <= TOLSQ_W'(r_tol) * TOLSQ_W'(r_tol);
            if (n_en) begin
                r_vld       <= {r_vld[ARM_LAT-2:0], s_axis_tvalid};
                r_cv        <= r_vld[ARM_LAT-1];
                r_out_valid <= r_cv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_vis[0] <= s_axis_tdata[162:160];
            for (int s = 1; s < ARM_LAT; s++) begin
                r_vis[s] <= r_vis[s-1];
            end
            for (int a = 0; a < ARMS; a++) begin
                r_cand[a] <= r_vis[ARM_LAT-1][a] && (w_dist[a] < n_lim);
            end
            r_cvis    <= r_vis[ARM_LAT-1];
            r_lt10    <= w_dist[1] < w_dist[0];
            r_lt20    <= w_dist[2] < w_dist[0];
            r_lt21    <= w_dist[2] < w_dist[1];
            r_hit     <= n_hit;
            r_out_vis <= r_cvis;
        end
    end

`include "nearest_arm_hit_test_unit_assert.svh"

    `NAHIT_ASSERT_SAME(a_hit_visible, r_out_valid && (r_hit != HIT_NONE), r_out_vis[r_hit - 2'd1])
    `NAHIT_ASSERT_SAME(a_zero_tol_miss, r_out_valid && (r_tol_sq == '0) && (r_tol == '0), r_hit == HIT_NONE)
    `NAHIT_ASSERT_NEXT(a_enter_pipe, s_axis_tvalid && s_axis_tready, r_vld[0])
    `NAHIT_ASSERT_NEXT(a_hold_out, r_out_valid && !m_axis_tready, r_out_valid && $stable(r_hit))

endmodule

// ===== sv/nahit_arm.sv =====
// Pipelined squared distance from the cursor to one arm segment.
// Depends on nahit_pkg.
module nahit_arm (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [nahit_pkg::COORD_W-1:0] i_cx,
    input  logic signed [nahit_pkg::COORD_W-1:0] i_cy,
    input  logic signed [nahit_pkg::COORD_W-1:0] i_ox,
    input  logic signed [nahit_pkg::COORD_W-1:0] i_oy,
    input  logic signed [nahit_pkg::COORD_W-1:0] i_tx,
    input  logic signed [nahit_pkg::COORD_W-1:0] i_ty,
    output logic [nahit_pkg::DIST_W-1:0]   o_dist2
);
    import nahit_pkg::*;

    localparam int DS = 2;   // stage of the first divider register
    localparam int DL = DS + DIV_STG;

    logic signed [DIFF_W-1:0] r_ux [DL + 1];
    logic signed [DIFF_W-1:0] r_uy [DL + 1];
    logic signed [DIFF_W-1:0] r_dx [DL + 1];
    logic signed [DIFF_W-1:0] r_dy [DL + 1];
    logic signed [PROD_W-1:0] r_pux, r_puy, r_pdx, r_pdy;
    logic [LEN_W-1:0]         r_len [DIV_STG + 1];
    logic                     r_pos [DIV_STG + 1];
    logic                     r_ge  [DIV_STG + 1];
    t_div                     r_div [DIV_STG + 1];
    logic signed [TP_W-1:0]   r_tpx, r_tpy;
    logic signed [DIFF_W-1:0] r_ux2, r_uy2;
    logic [MAG_W-1:0]         r_ex, r_ey;
    logic [2*HALF_W-1:0]      r_xhh, r_xhl, r_xll, r_yhh, r_yhl, r_yll;
    logic [DIST_W-1:0]        r_dist;

    logic signed [DOT_W-1:0]  n_dot;
    logic [DOT_W-1:0]         n_len;
    logic [TQ_W-1:0]          n_tq;
    logic signed [ERR_W-1:0]  n_ex, n_ey;
    logic [ERR_W-1:0]         n_ax, n_ay;
    logic [SQ_W-1:0]          n_sx, n_sy;

    always_comb begin
        n_dot = DOT_W'(r_pux) + DOT_W'(r_puy);
        n_len = DOT_W'(unsigned'(r_pdx)) + DOT_W'(unsigned'(r_pdy));
        if (!r_pos[DIV_STG]) begin
            n_tq = '0;
        end else if (r_ge[DIV_STG]) begin
            n_tq = TQ_W'(1) << FRAC_W;
        end else begin
            n_tq = {1'b0, r_div[DIV_STG].quo};
        end
        n_ex = (ERR_W'(r_ux2) <<< FRAC_W) - ERR_W'(r_tpx);
        n_ey = (ERR_W'(r_uy2) <<< FRAC_W) - ERR_W'(r_tpy);
        n_ax = n_ex[ERR_W-1] ? ERR_W'(-n_ex) : ERR_W'(n_ex);
        n_ay = n_ey[ERR_W-1] ? ERR_W'(-n_ey) : ERR_W'(n_ey);
        n_sx = (SQ_W'(r_xhh) << (2 * HALF_W)) + (SQ_W'(r_xhl) << (HALF_W + 1))
             + SQ_W'(r_xll);
        n_sy = (SQ_W'(r_yhh) << (2 * HALF_W)) + (SQ_W'(r_yhl) << (HALF_W + 1))
             + SQ_W'(r_yll);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ux[0] <= DIFF_W'(i_cx) - DIFF_W'(i_ox);
            r_uy[0] <= DIFF_W'(i_cy) - DIFF_W'(i_oy);
            r_dx[0] <= DIFF_W'(i_tx) - DIFF_W'(i_ox);
            r_dy[0] <= DIFF_W'(i_ty) - DIFF_W'(i_oy);
            for (int s = 1; s < DL + 1; s++) begin
                r_ux[s] <= r_ux[s-1];
                r_uy[s] <= r_uy[s-1];
                r_dx[s] <= r_dx[s-1];
                r_dy[s] <= r_dy[s-1];
            end
            r_pux <= r_ux[0] * r_dx[0];
            r_puy <= r_uy[0] * r_dy[0];
            r_pdx <= r_dx[0] * r_dx[0];
            r_pdy <= r_dy[0] * r_dy[0];
            r_len[0]     <= n_len[LEN_W-1:0];
            r_pos[0]     <= !n_dot[DOT_W-1] && (n_dot != '0);
            r_ge[0]      <= n_dot >= signed'(n_len);
            r_div[0].rem <= n_dot[LEN_W-1:0];
            r_div[0].quo <= '0;
            for (int s = 1; s <= DIV_STG; s++) begin
                r_len[s] <= r_len[s-1];
                r_pos[s] <= r_pos[s-1];
                r_ge[s]  <= r_ge[s-1];
                r_div[s] <= div_step(r_div[s-1], r_len[s-1]);
            end
            r_tpx <= r_dx[DL] * signed'({1'b0, n_tq});
            r_tpy <= r_dy[DL] * signed'({1'b0, n_tq});
            r_ux2 <= r_ux[DL];
            r_uy2 <= r_uy[DL];
            r_ex  <= n_ax[MAG_W-1:0];
            r_ey  <= n_ay[MAG_W-1:0];
            r_xhh <= r_ex[MAG_W-1:HALF_W] * r_ex[MAG_W-1:HALF_W];
            r_xhl <= r_ex[MAG_W-1:HALF_W] * r_ex[HALF_W-1:0];
            r_xll <= r_ex[HALF_W-1:0] * r_ex[HALF_W-1:0];
            r_yhh <= r_ey[MAG_W-1:HALF_W] * r_ey[MAG_W-1:HALF_W];
            r_yhl <= r_ey[MAG_W-1:HALF_W] * r_ey[HALF_W-1:0];
            r_yll <= r_ey[HALF_W-1:0] * r_ey[HALF_W-1:0];
            r_dist <= DIST_W'(n_sx) + DIST_W'(n_sy);
        end
    end

    assign o_dist2 = r_dist;

endmodule

// ===== dv/nearest_arm_hit_test_unit_tb.sv =====
// Testbench for nearest_arm_hit_test_unit: directed table then random hit-test queries,
// each result checked against an exact integer model of the arm distances.
// Depends on nahit_pkg and the unit RTL.
`timescale 1ns / 1ps

module nearest_arm_hit_test_unit_tb;
    import nahit_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct {
        logic [15:0] cx, cy, ox, oy;
        logic [15:0] tx [3];
        logic [15:0] ty [3];
        logic [2:0]  vis;
    } query_t;

    typedef struct {
        query_t           q;
        bit               has_exp;
        logic [HIT_W-1:0] exp_hit;
    } row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [TOL_W-1:0]       i_cfg_data = '0;

    nearest_arm_hit_test_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [TOL_W-1:0]  tolerance;
    logic [HIT_W-1:0]  expected_hits[$];
    row_t              rows[$];
    int                errors = 0;
    int                cycles = 0;
    int                send_idle = 0;
    int                recv_idle = 0;
    int                hold_off = 0;
    bit                pressure_req = 1'b0;
    bit                pressure_done = 1'b0;

    // exact squared distance scaled by 2^32
    function automatic logic [127:0] arm_dist_sq(longint ux, longint uy, longint dx,
                                                 longint dy);
        longint   len2, dotp, tq, ex, ey;
        logic [127:0] ax, ay;
        len2 = dx * dx + dy * dy;
        dotp = ux * dx + uy * dy;
        if (dotp <= 0) tq = 0;
        else if (dotp >= len2) tq = 64'd65536;
        else tq = (dotp * 65536) / len2;
        ex = ux * 65536 - dx * tq;
        ey = uy * 65536 - dy * tq;
        ax = (ex < 0) ? -ex : ex;
        ay = (ey < 0) ? -ey : ey;
        return ax * ax + ay * ay;
    endfunction

    function automatic logic [HIT_W-1:0] nearest_arm(query_t q);
        logic [127:0]     best, d2, tl;
        logic [HIT_W-1:0] hit;
        longint           ux, uy;
        hit = HIT_NONE;
        tl = {tolerance, 16'd0};
        best = tl * tl;
        ux = longint'($signed(q.cx)) - longint'($signed(q.ox));
        uy = longint'($signed(q.cy)) - longint'($signed(q.oy));
        for (int a = 0; a < ARMS; a++) begin
            if (q.vis[a]) begin
                d2 = arm_dist_sq(ux, uy, longint'($signed(q.tx[a])) - longint'($signed(q.ox)),
                                 longint'($signed(q.ty[a])) - longint'($signed(q.oy)));
                if (d2 < best) begin
                    best = d2;
                    hit = HIT_W'(a + 1);
                end
            end
        end
        return hit;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_query(query_t q);
        return {5'd0, q.vis, q.ty[2], q.tx[2], q.ty[1], q.tx[1], q.ty[0], q.tx[0],
                q.oy, q.ox, q.cy, q.cx};
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic send_query(query_t q);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= pack_query(q);
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic push_query(query_t q, bit has_exp, logic [HIT_W-1:0] want);
        logic [HIT_W-1:0] hit;
        hit = nearest_arm(q);
        if (has_exp && hit != want) report_mismatch("table row", hit, want);
        expected_hits = {expected_hits, hit};
        send_query(q);
    endtask

    task automatic add_row(query_t q, bit has_exp, logic [HIT_W-1:0] want);
        row_t r;
        r.q = q;
        r.has_exp = has_exp;
        r.exp_hit = want;
        rows = {rows, r};
    endtask

    task automatic set_tolerance(logic [TOL_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (ARM_LAT + 8) @(posedge i_clk);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tolerance = v;
    endtask

    function automatic logic [15:0] rand_coord(int spread);
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom_range(2 * spread) - spread);
        endcase
    endfunction

    function automatic query_t rand_query();
        query_t q;
        int     spread;
        spread = ($urandom_range(3) == 0) ? 32768 : 400;
        q.ox = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(800) - 400);
        q.oy = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(800) - 400);
        q.cx = (spread > 400) ? 16'($urandom) : q.ox + rand_coord(spread);
        q.cy = (spread > 400) ? 16'($urandom) : q.oy + rand_coord(spread);
        for (int a = 0; a < ARMS; a++) begin
            q.tx[a] = (spread > 400) ? 16'($urandom) : q.ox + rand_coord(1600);
            q.ty[a] = (spread > 400) ? 16'($urandom) : q.oy + rand_coord(1600);
            if ($urandom_range(9) == 0) begin
                q.tx[a] = q.ox;
                q.ty[a] = q.oy;
            end
        end
        q.vis = 3'($urandom);
        return q;
    endfunction

    function automatic query_t mk(int cx, int cy, int ox, int oy, int t0x, int t0y,
                                  int t1x, int t1y, int t2x, int t2y, int vis);
        query_t q;
        q.cx = 16'(cx); q.cy = 16'(cy); q.ox = 16'(ox); q.oy = 16'(oy);
        q.tx[0] = 16'(t0x); q.ty[0] = 16'(t0y);
        q.tx[1] = 16'(t1x); q.ty[1] = 16'(t1y);
        q.tx[2] = 16'(t2x); q.ty[2] = 16'(t2y);
        q.vis = 3'(vis);
        return q;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_hits.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[HIT_W-1:0], -1);
            end else begin
                if (m_axis_tdata[HIT_W-1:0] != expected_hits[0])
                    report_mismatch("hit_axis", m_axis_tdata[HIT_W-1:0], expected_hits[0]);
                void'(expected_hits.pop_front());
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (pressure_req && !pressure_done) begin
            pressure_done <= 1'b1;
            hold_off <= 60;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
        end
    end

    initial begin
        add_row(mk(0, 0, 0, 0, 1000, 0, 0, 1000, 0, 0, 7), 1, HIT_X);
        add_row(mk(0, 500, 0, 0, 1000, 0, 0, 1000, 0, 0, 7), 1, HIT_Y);
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4), 1, HIT_Z);
        add_row(mk(0, 0, 0, 0, 1000, 0, 0, 1000, 0, 0, 0), 1, HIT_NONE);
        add_row(mk(5000, 5000, 0, 0, 1000, 0, 0, 1000, 0, 0, 7), 1, HIT_NONE);
        add_row(mk(127, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, HIT_X);
        add_row(mk(128, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, HIT_NONE);
        add_row(mk(-50, 0, 0, 0, 1000, 0, 0, 1000, 0, 0, 3), 0, HIT_NONE);
        add_row(mk(1100, 10, 0, 0, 1000, 0, 1000, 0, 0, 0, 7), 0, HIT_NONE);
        add_row(mk(333, 77, 0, 0, 1000, 300, -1000, 0, 7, 999, 7), 0, HIT_NONE);
        add_row(mk(-32768, -32768, 32767, 32767, -32768, -32768, 32767, -32768,
                   -32768, 32767, 7), 0, HIT_NONE);
        add_row(mk(32767, 32767, -32768, -32768, 32767, 32767, 32767, -32768,
                   -32768, 32767, 7), 0, HIT_NONE);
        add_row(mk(-1, -1, -32768, 32767, 32767, -32768, -1, -1, 0, 0, 6), 0, HIT_NONE);
        tolerance = TOL_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) push_query(rows[i].q, rows[i].has_exp, rows[i].exp_hit);
        set_tolerance('0);
        push_query(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 7), 1, HIT_NONE);
        set_tolerance(15'h7fff);
        push_query(mk(-32768, -32768, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 7), 0, 0);
        push_query(mk(100, 100, 0, 0, 100, 100, 100, 100, 0, 0, 7), 1, HIT_X);
        for (int p = 0; p < 3; p++) begin
            send_idle = (p == 0) ? 34 : (p == 1) ? 71 : 0;
            recv_idle = (p == 0) ? 71 : (p == 1) ? 34 : 0;
            case (p)
                0: set_tolerance(15'd200);
                1: set_tolerance(15'($urandom_range(2000)));
                default: set_tolerance(15'($urandom));
            endcase
            if (p == 2) pressure_req = 1'b1;
            repeat (260) push_query(rand_query(), 0, 0);
        end
        s_axis_tvalid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (ARM_LAT + 20) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+sv
sv/nahit_pkg.sv
sv/nahit_arm.sv
sv/nearest_arm_hit_test_unit.sv
dv/nearest_arm_hit_test_unit_tb.sv
